@@ sv/mpq_pkg.sv @@
// Shared constants and types for the min-first priority queue.
package mpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PRIO_BITS_DEF   = 8;
    localparam int TAG_BITS_DEF    = 16;

    localparam int STATUS_BITS = 2;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

    // Chain-wide control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } mpq_ctrl_t;

endpackage

@@ sv/mpq_cell.sv @@
// One storage cell of the sorted queue chain.
module mpq_cell #(
    parameter int PRIO_BITS = mpq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = mpq_pkg::TAG_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mpq_pkg::mpq_ctrl_t   ctrl,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic [TAG_BITS-1:0]  new_tag,
    input  logic                 left_keep,
    input  logic                 left_valid,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic [TAG_BITS-1:0]  left_tag,
    input  logic                 right_valid,
    input  logic [PRIO_BITS-1:0] right_prio,
    input  logic [TAG_BITS-1:0]  right_tag,
    output logic                 keep,
    output logic                 valid,
    output logic [PRIO_BITS-1:0] prio,
    output logic [TAG_BITS-1:0]  tag
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [TAG_BITS-1:0]  tag_next;

    // An equal priority stays ahead of the newcomer: arrival order among ties
    assign keep = valid_reg && (prio_reg <= new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        tag_next   = tag_reg;
        if (ctrl.pop)
        begin
            valid_next = right_valid;
            prio_next  = right_prio;
            tag_next   = right_tag;
        end
        else if (ctrl.push && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                prio_next  = new_prio;
                tag_next   = new_tag;
            end
            else
            begin
                valid_next = left_valid;
                prio_next  = left_prio;
                tag_next   = left_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign valid = valid_reg;
    assign prio  = prio_reg;
    assign tag   = tag_reg;

endmodule

@@ sv/min_priority_queue_fifo_ties_top.sv @@
// Min-first priority queue with first-come order among equal priorities, built as
// a sorted chain of QUEUE_DEPTH cells. Each beat is an enqueue or a dequeue and
// yields exactly one registered result beat. Every cell compares only its own
// priority with the incoming one and takes data from itself, a neighbour or the
// input, so one beat is taken every clock; input ready drops only while a result
// waits unconsumed and the output side is stalled. Dequeue returns cell 0, the head.
module min_priority_queue_fifo_ties_top #(
    parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIO_BITS   = mpq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS    = mpq_pkg::TAG_BITS_DEF,
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [TAG_BITS-1:0]             tag,
    input  logic [PRIO_BITS-1:0]            priority_req,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mpq_pkg::STATUS_BITS-1:0] status,
    output logic [TAG_BITS-1:0]             out_tag,
    output logic [PRIO_BITS-1:0]            out_priority,
    output logic [CNT_BITS-1:0]             occupancy
);

    logic                 cell_valid [QUEUE_DEPTH];
    logic                 cell_keep  [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] cell_prio  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  cell_tag   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;

    mpq_pkg::mpq_ctrl_t ctrl;

    logic accept;
    logic full;
    logic empty;

    logic                            out_valid_reg;
    logic [mpq_pkg::STATUS_BITS-1:0] status_reg;
    logic [mpq_pkg::STATUS_BITS-1:0] status_next;
    logic [TAG_BITS-1:0]             out_tag_reg;
    logic [TAG_BITS-1:0]             out_tag_next;
    logic [PRIO_BITS-1:0]            out_prio_reg;
    logic [PRIO_BITS-1:0]            out_prio_next;
    logic [CNT_BITS-1:0]             count_reg;
    logic [CNT_BITS-1:0]             count_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = cell_valid[QUEUE_DEPTH-1];
    assign empty    = !cell_valid[0];

    assign ctrl.push = accept && (cmd == mpq_pkg::CMD_ENQ) && !full;
    assign ctrl.pop  = accept && (cmd == mpq_pkg::CMD_DEQ) && !empty;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                 l_keep;
            logic                 l_valid;
            logic [PRIO_BITS-1:0] l_prio;
            logic [TAG_BITS-1:0]  l_tag;
            logic                 r_valid;
            logic [PRIO_BITS-1:0] r_prio;
            logic [TAG_BITS-1:0]  r_tag;

            if (i == 0)
            begin : g_head
                // Head cell: newcomer lands here unless the head stays
                assign l_keep  = 1'b1;
                assign l_valid = 1'b0;
                assign l_prio  = '0;
                assign l_tag   = '0;
            end
            else
            begin : g_mid
                assign l_keep  = cell_keep[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_prio  = cell_prio[i-1];
                assign l_tag   = cell_tag[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_prio  = '0;
                assign r_tag   = '0;
            end
            else
            begin : g_body
                assign r_valid = cell_valid[i+1];
                assign r_prio  = cell_prio[i+1];
                assign r_tag   = cell_tag[i+1];
            end

            mpq_cell #(
                .PRIO_BITS (PRIO_BITS),
                .TAG_BITS  (TAG_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_prio    (priority_req),
                .new_tag     (tag),
                .left_keep   (l_keep),
                .left_valid  (l_valid),
                .left_prio   (l_prio),
                .left_tag    (l_tag),
                .right_valid (r_valid),
                .right_prio  (r_prio),
                .right_tag   (r_tag),
                .keep        (cell_keep[i]),
                .valid       (cell_valid[i]),
                .prio        (cell_prio[i]),
                .tag         (cell_tag[i])
            );

            assign valid_vec[i] = cell_valid[i];
        end
    endgenerate

    always_comb
    begin
        status_next   = mpq_pkg::STAT_OK;
        out_tag_next  = '0;
        out_prio_next = '0;
        count_next    = count_reg;
        if (cmd == mpq_pkg::CMD_ENQ)
        begin
            if (full)
            begin
                status_next = mpq_pkg::STAT_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = mpq_pkg::STAT_EMPTY;
            end
            else
            begin
                out_tag_next  = cell_tag[0];
                out_prio_next = cell_prio[0];
                count_next    = count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            out_tag_reg  <= out_tag_next;
            out_prio_reg <= out_prio_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = count_reg;

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("entry count disagrees with occupied cells");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_prio[0] <= cell_prio[1]))
        else $error("head cell is not the minimum of its neighbour");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == mpq_pkg::STAT_FULL) |->
            (32'(occupancy) == QUEUE_DEPTH))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == mpq_pkg::STAT_EMPTY) |-> (occupancy == '0))
        else $error("empty status with entries held");

endmodule

@@ tb/min_priority_queue_fifo_ties_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the min-first priority queue with first-come order on ties.
module min_priority_queue_fifo_ties_top_test;

    localparam int DEPTH        = mpq_pkg::QUEUE_DEPTH_DEF;
    localparam int PW           = mpq_pkg::PRIO_BITS_DEF;
    localparam int TW           = mpq_pkg::TAG_BITS_DEF;
    localparam int SW           = mpq_pkg::STATUS_BITS;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1530;
    localparam int MAX_WAIT     = 10;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic          op;
        logic [TW-1:0] tag;
        logic [PW-1:0] prio;
    } request_t;

    typedef struct packed {
        logic [SW-1:0] status;
        logic [TW-1:0] tag;
        logic [PW-1:0] prio;
        logic [CW-1:0] count;
    } reply_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    logic          cmd          = mpq_pkg::CMD_ENQ;
    logic [TW-1:0] tag          = '0;
    logic [PW-1:0] priority_req = '0;
    logic          out_ready    = 1'b0;
    logic          in_ready;
    logic          out_valid;
    logic [SW-1:0] status;
    logic [TW-1:0] out_tag;
    logic [PW-1:0] out_priority;
    logic [CW-1:0] occupancy;

    // Entries the block should hold, kept in arrival order with the oldest in slot 0
    logic [TW-1:0] held_tag [DEPTH];
    logic [PW-1:0] held_prio[DEPTH];
    int            held_count;

    request_t request_q[$];
    reply_t   reply_q[$];

    int  send_gap, recv_gap;
    bit  send_burst, recv_burst;
    int  errors, cycles, results_seen;
    int  enq_taken, enq_dropped, deq_served, deq_empty, peak_count;

    min_priority_queue_fifo_ties_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .tag          (tag),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the held queue and return the reply it should produce
    function automatic reply_t serve_request(request_t rq);
        reply_t rp;
        int     best;
        rp = '0;
        rp.status = mpq_pkg::STAT_OK;
        if (rq.op == mpq_pkg::CMD_ENQ)
        begin
            if (held_count >= DEPTH)
            begin
                rp.status = mpq_pkg::STAT_FULL;
                enq_dropped++;
            end
            else
            begin
                held_tag[held_count]  = rq.tag;
                held_prio[held_count] = rq.prio;
                held_count++;
                enq_taken++;
            end
        end
        else if (held_count == 0)
        begin
            rp.status = mpq_pkg::STAT_EMPTY;
            deq_empty++;
        end
        else
        begin
            // strict less-than keeps the earliest arrival among equal priorities
            best = 0;
            for (int i = 1; i < held_count; i++)
                if (held_prio[i] < held_prio[best])
                    best = i;
            rp.tag  = held_tag[best];
            rp.prio = held_prio[best];
            for (int i = best; i + 1 < held_count; i++)
            begin
                held_tag[i]  = held_tag[i + 1];
                held_prio[i] = held_prio[i + 1];
            end
            held_count--;
            deq_served++;
        end
        if (held_count > peak_count)
            peak_count = held_count;
        rp.count = CW'(held_count);
        return rp;
    endfunction

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic add_request(logic op, logic [TW-1:0] t, logic [PW-1:0] p);
        request_t rq;
        rq.op   = op;
        rq.tag  = t;
        rq.prio = p;
        request_q.push_back(rq);
    endtask

    task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Driver: present one beat at a time, with a drawn gap after each
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt, taken;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            cmd          <= mpq_pkg::CMD_ENQ;
            tag          <= '0;
            priority_req <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken.op   = cmd;
                taken.tag  = tag;
                taken.prio = priority_req;
                reply_q.push_back(serve_request(taken));
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    nxt = request_q.pop_front();
                    in_valid     <= 1'b1;
                    cmd          <= nxt.op;
                    tag          <= nxt.tag;
                    priority_req <= nxt.prio;
                    send_gap = draw_wait(send_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: take result beats, compare against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (reply_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got status %0d tag %0d",
                             $time, status, out_tag);
                end
                else
                begin
                    want = reply_q.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("out_tag", want.tag, out_tag);
                    check_field("out_priority", 16'(want.prio), 16'(out_priority));
                    check_field("occupancy", 16'(want.count), 16'(occupancy));
                end
                recv_gap = draw_wait(recv_burst);
                out_ready <= (recv_gap == 0);
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= (recv_gap == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, reply_q.size());
            $display("[min_priority_queue_fifo_ties_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int          seg_left, enq_pct, prio_mode;
        logic        op;
        logic [PW-1:0] p;

        // Directed: dequeue on empty, fill with extremes and ties, overflow, partial drain
        add_request(mpq_pkg::CMD_DEQ, 16'h0000, 8'h00);
        add_request(mpq_pkg::CMD_ENQ, 16'hFFFF, 8'hFF);
        add_request(mpq_pkg::CMD_ENQ, 16'h0000, 8'h00);
        add_request(mpq_pkg::CMD_ENQ, 16'h1234, 8'h80);
        add_request(mpq_pkg::CMD_ENQ, 16'hAAAA, 8'h00);
        add_request(mpq_pkg::CMD_ENQ, 16'h5555, 8'hFF);
        add_request(mpq_pkg::CMD_ENQ, 16'h0001, 8'h80);
        for (int i = 0; i < DEPTH - 6; i++)
            add_request(mpq_pkg::CMD_ENQ, 16'h0100 + 16'(i), 8'h40 + 8'(i % 3));
        add_request(mpq_pkg::CMD_ENQ, 16'hBEEF, 8'h00);
        for (int i = 0; i < 5; i++)
            add_request(mpq_pkg::CMD_DEQ, 16'hFFFF, 8'hFF);

        // Random segments with shifting enqueue bias so full and empty are both hit
        seg_left = 0;
        enq_pct = 50;
        prio_mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left  = $urandom_range(20, 60);
                enq_pct   = 10 + 20 * $urandom_range(0, 4);
                prio_mode = $urandom_range(0, 2);
            end
            seg_left--;
            op = ($urandom_range(0, 99) < enq_pct) ? mpq_pkg::CMD_ENQ : mpq_pkg::CMD_DEQ;
            case (prio_mode)
                0: p = PW'($urandom_range(0, 255));
                1: p = PW'($urandom_range(0, 3));
                default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            add_request(op, TW'($urandom_range(0, 65535)), p);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() > 0 || in_valid || reply_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d enqueues stored, %0d dropped when full,",
                 results_seen, enq_taken, enq_dropped);
        $display("%0d dequeues served, %0d on empty, peak occupancy %0d of %0d.",
                 deq_served, deq_empty, peak_count, DEPTH);
        if (errors == 0 && reply_q.size() == 0)
            $display("[min_priority_queue_fifo_ties_top] OK");
        else
            $display("[min_priority_queue_fifo_ties_top] ERROR");
        $finish;
    end

endmodule
